// File: rtl/core/sosc_pkg.sv
// sosc_pkg: shared constants, register indexes and the quarter-wave sine
// builder for the sine oscillator. No dependencies.

package sosc_pkg;

  // Configuration register map (word index = paddr[3:2])
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    REG_TUNING_WORD  = 2'd0,
    REG_START_PHASE  = 2'd1,
    REG_AMPLITUDE    = 2'd2,
    REG_SAMPLE_COUNT = 2'd3
  } reg_idx_e;

  // Fixed-point constants of the sine table
  localparam int unsigned FracBits   = 30;
  localparam logic [63:0] HalfPiQ30  = 64'd1686629713;
  localparam logic [15:0] SinePeak   = 16'd32767;
  localparam int unsigned TaylorTerms = 10;

  // Taylor divisors (2n)(2n+1) for n = 1..10, index n-1
  localparam logic [63:0] TaylorDiv [TaylorTerms] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
    64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

  // Quarter-wave entry: sin(pi/2 * idx / 2^abits) in Q1.15, evaluated at
  // elaboration from a Q30 Taylor series with truncating steps.
  function automatic logic [15:0] quarter_sine(input int unsigned idx,
                                               input int unsigned abits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x    = (HalfPiQ30 * 64'(idx)) >> abits;
    x2   = (x * x) >> FracBits;
    term = x;
    sum  = x;
    for (int unsigned n = 1; n <= TaylorTerms; n++) begin
      term = ((term * x2) >> FracBits) / TaylorDiv[n-1];
      if ((n % 2) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * 64'(SinePeak) + (64'd1 << (FracBits - 1))) >> FracBits;
    if (v > 64'(SinePeak)) begin
      v = 64'(SinePeak);
    end
    return v[15:0];
  endfunction

endpackage

// File: rtl/core/sosc_rom.sv
// sosc_rom: quarter-wave sine ROM with registered read.
// Contents come from sosc_pkg::quarter_sine at elaboration.

module sosc_rom #(
  parameter int unsigned AddrBits = 10
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [AddrBits-1:0] addr_i,
  output logic [15:0]         data_o
);

  localparam int unsigned Depth = 1 << AddrBits;

  logic [15:0] rom_w [Depth];
  logic [15:0] data_q;

  // Constant contents
  for (genvar g = 0; g < Depth; g++) begin : g_rom
    assign rom_w[g] = sosc_pkg::quarter_sine(g, AddrBits);
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= rom_w[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// File: rtl/core/sine_oscillator.sv
// sine_oscillator: top level of the phase-accumulator sine oscillator.
// Uses sosc_pkg and sosc_rom.

// One word in gives one sample out, and a word can be accepted every clock
// cycle unless back-pressure fills the pipe. From acceptance to out_valid_o,
// the phase and block counter update and the ROM address form in the accept
// cycle, the registered ROM read fills the middle stage, and the amplitude
// multiply with round-half-up fills the output register. The rate is set by
// the phase/counter update loop; output back-pressure stalls the pipe, but
// an empty middle stage still takes a word while a finished sample waits. The
// phase is a 32-bit fraction of a turn; start_phase is used for the first
// sample of each block (after reset, after a last sample, or with restart_i).
// Registers (32-bit APB, byte address 4*i): 0 tuning_word, 1 start_phase,
// 2 amplitude (Q0.16), 3 sample_count (0 acts as 1). Write them only while
// the block is idle.

module sine_oscillator #(
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // APB configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sosc_pkg::AddrW-1:0] paddr,
  input  logic [sosc_pkg::DataW-1:0] pwdata,
  output logic [sosc_pkg::DataW-1:0] prdata,
  output logic                       pready,
  // Input channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       restart_i,
  // Output channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [15:0]         sample_o,
  output logic                       last_o
);

  localparam int unsigned Ab = TABLE_ADDR_BITS;

  typedef struct packed {
    logic neg;
    logic peak;
    logic last;
  } s1_ctrl_t;

  // ---------------------------------------------------------------------
  // Configuration registers
  logic [31:0] tuning_q, start_phase_q, count_q;
  logic [15:0] amp_q;
  logic        cfg_wr;
  sosc_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = sosc_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tuning_q      <= '0;
      start_phase_q <= '0;
      amp_q         <= '0;
      count_q       <= 32'd1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        sosc_pkg::REG_TUNING_WORD:  tuning_q      <= pwdata;
        sosc_pkg::REG_START_PHASE:  start_phase_q <= pwdata;
        sosc_pkg::REG_AMPLITUDE:    amp_q         <= pwdata[15:0];
        sosc_pkg::REG_SAMPLE_COUNT: count_q       <= pwdata;
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    case (cfg_idx)
      sosc_pkg::REG_TUNING_WORD:  prdata = tuning_q;
      sosc_pkg::REG_START_PHASE:  prdata = start_phase_q;
      sosc_pkg::REG_AMPLITUDE:    prdata = {16'd0, amp_q};
      sosc_pkg::REG_SAMPLE_COUNT: prdata = count_q;
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control
  logic s1_valid_q, out_valid_q;
  logic out_adv, s1_adv, in_acc;

  assign out_adv    = !out_valid_q || out_ready_i;
  assign s1_adv     = !s1_valid_q || out_adv;
  assign in_ready_o = s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------
  // Stage 0: phase select, block counter, ROM address
  logic [31:0] acc_q, acc_d, idx_q, idx_d, idx_eff, phase;
  logic [32:0] idx_next;
  logic        blk_start, last_w;
  logic [1:0]  quad;
  logic [Ab-1:0] k, rom_addr;
  s1_ctrl_t    s1_d;

  always_comb begin
    idx_eff   = restart_i ? 32'd0 : idx_q;
    blk_start = (idx_eff == 32'd0);
    phase     = blk_start ? start_phase_q : acc_q;
    idx_next  = {1'b0, idx_eff} + 33'd1;
    last_w    = (idx_next >= {1'b0, count_q});
    if (last_w) begin
      idx_d = '0;
      acc_d = start_phase_q;
    end else begin
      idx_d = idx_next[31:0];
      acc_d = phase + tuning_q;
    end
    quad      = phase[31:30];
    k         = phase[29 -: Ab];
    // odd quadrants mirror the table; k of zero there is the peak
    rom_addr  = quad[0] ? (Ab'(0) - k) : k;
    s1_d.neg  = quad[1];
    s1_d.peak = quad[0] && (k == '0);
    s1_d.last = last_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      idx_q <= '0;
    end else if (in_acc) begin
      acc_q <= acc_d;
      idx_q <= idx_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: ROM read
  logic [15:0] rom_data;
  s1_ctrl_t    s1_q;

  sosc_rom #(
    .AddrBits(Ab)
  ) u_rom (
    .clk_i (clk_i),
    .en_i  (s1_adv),
    .addr_i(rom_addr),
    .data_o(rom_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: sign, amplitude multiply, round half up to Q1.15
  logic [15:0]        mag;
  logic signed [16:0] sine_s;
  logic signed [33:0] prod, rounded;
  logic signed [15:0] sample_q;
  logic               last_q;

  always_comb begin
    mag     = s1_q.peak ? sosc_pkg::SinePeak : rom_data;
    sine_s  = s1_q.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    prod    = 34'(sine_s) * 34'($signed({1'b0, amp_q}));
    rounded = (prod + 34'sd32768) >>> 16;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      sample_q <= rounded[15:0];
      last_q   <= s1_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign last_o      = last_q;

endmodule

// File: rtl/core/sosc_checker.sv
// sosc_checker: port-level assertions for sine_oscillator, bound to the
// top level below. Uses sosc_pkg for register indexes.

module sosc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [sosc_pkg::AddrW-1:0] paddr,
  input logic [sosc_pkg::DataW-1:0] pwdata,
  input logic [sosc_pkg::DataW-1:0] prdata,
  input logic                       pready,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic signed [15:0]         sample_o,
  input logic                       last_o
);

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_o) && $stable(last_o))
    else $error("output word changed while stalled");

  // Input only stalls when a finished sample is waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // Full-width registers read back what was just written
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && $past(psel && penable && pwrite && pready) && psel && !pwrite
    && paddr[3:2] == $past(paddr[3:2])
    && paddr[3:2] != sosc_pkg::REG_AMPLITUDE
    |-> prdata == $past(pwdata))
    else $error("register read-back mismatch");

  // Amplitude reads back its low 16 bits, zero above
  a_amp_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && $past(psel && penable && pwrite && pready) && psel && !pwrite
    && paddr[3:2] == $past(paddr[3:2])
    && paddr[3:2] == sosc_pkg::REG_AMPLITUDE
    |-> prdata[31:16] == 16'd0 && prdata[15:0] == $past(pwdata[15:0]))
    else $error("amplitude read-back mismatch");

endmodule

bind sine_oscillator sosc_checker u_sosc_checker (.*);
